FILE: src/motor_feedback_encoder_unwrap_core_defines.svh
// Assertion macros shared by the motor feedback unwrap RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MOTOR_FEEDBACK_ENCODER_UNWRAP_CORE_DEFINES_SVH
`define MOTOR_FEEDBACK_ENCODER_UNWRAP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MFEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MFEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mfeu_pkg.sv
// Types and constants for the motor feedback decoder and encoder unwrap.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfeu_pkg;

   // Encoder counts per revolution (16 .. 32768)
   localparam int ENC_COUNTS = 8192;

   // Unwrapped step width: holds a 16-bit difference plus one revolution
   localparam int STEP_W = 18;
   localparam logic signed [STEP_W-1:0] ENC_COUNTS_S = STEP_W'(ENC_COUNTS);
   localparam logic signed [STEP_W-1:0] ENC_HALF_S   = STEP_W'(ENC_COUNTS / 2);

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 144;
   localparam int RSP_TUSER_W = 2;

   // Configuration register indexes
   localparam logic CSR_MATCH_ID   = 1'b0;
   localparam logic CSR_MOTOR_KIND = 1'b1;

   // motor_kind codes
   localparam logic [1:0] KIND_GEAR_OUTPUT = 2'd0;
   localparam logic [1:0] KIND_CURRENT     = 2'd1;
   localparam logic [1:0] KIND_VOLTAGE     = 2'd2;

   localparam logic [10:0] MATCH_ID_RST = 11'd513;

   typedef struct packed {
      logic [10:0] frame_id;
      logic [7:0]  data_byte0;
      logic [7:0]  data_byte1;
      logic [7:0]  data_byte2;
      logic [7:0]  data_byte3;
      logic [7:0]  data_byte4;
      logic [7:0]  data_byte5;
      logic [7:0]  data_byte6;
   } frame_type;

   typedef struct packed {
      logic [10:0] match_id;
      logic [1:0]  motor_kind;
   } cfg_type;

   typedef struct packed {
      logic               matched;
      logic signed [15:0] raw_position;
      logic signed [15:0] shaft_speed;
      logic signed [15:0] torque_value;
      logic               torque_is_output;
      logic [7:0]         temperature;
      logic signed [16:0] speed_change;
      logic signed [31:0] relative_count;
      logic signed [31:0] absolute_count;
   } result_type;

endpackage

`default_nettype wire

FILE: src/mfeu_in_reg.sv
// Input register of the feedback decoder: captures one frame beat and unpacks it.
// Depends on mfeu_pkg.
`default_nettype none

module mfeu_in_reg
   import mfeu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // frame_id[10:0], data_byte0..6 in 8-bit slots from bit 11 up, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   advance,
   output logic                        in_valid,
   output frame_type                   in_frame
);

   logic      valid_ff, valid_in;
   frame_type frame_ff, frame_in;
   logic      req_fire;

   assign req_tready = !valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      if (req_fire) begin
         valid_in            = 1'b1;
         frame_in.frame_id   = req_tdata[10:0];
         frame_in.data_byte0 = req_tdata[18:11];
         frame_in.data_byte1 = req_tdata[26:19];
         frame_in.data_byte2 = req_tdata[34:27];
         frame_in.data_byte3 = req_tdata[42:35];
         frame_in.data_byte4 = req_tdata[50:43];
         frame_in.data_byte5 = req_tdata[58:51];
         frame_in.data_byte6 = req_tdata[66:59];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      frame_ff <= frame_in;
   end

   assign in_valid = valid_ff;
   assign in_frame = frame_ff;

endmodule

`default_nettype wire

FILE: src/mfeu_track.sv
// Frame decode, speed delta and multi-turn position unwrap with saturating counts.
// Depends on mfeu_pkg and the assertion macros header.
`default_nettype none
`include "motor_feedback_encoder_unwrap_core_defines.svh"

module mfeu_track
   import mfeu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire frame_type  in_frame,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic               have_prev_ff, have_prev_in;
   logic signed [15:0] last_pos_ff, last_pos_in;
   logic signed [15:0] last_spd_ff, last_spd_in;
   logic signed [31:0] rel_total_ff, rel_total_in;
   logic signed [31:0] abs_total_ff, abs_total_in;

   logic                     hit;
   logic signed [15:0]       pos, spd, trq;
   logic signed [16:0]       dspd;
   logic [15:0]              diff16;
   logic signed [STEP_W-1:0] d_raw, d_lo, d_fix, step;
   logic signed [31:0]       abs_base, rel_next, abs_next;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [STEP_W-1:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {{(33-STEP_W){b[STEP_W-1]}}, b};
      if (s[32] != s[31]) begin
         sat_add = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   assign hit  = (in_frame.frame_id == cfg.match_id);
   assign pos  = {in_frame.data_byte0, in_frame.data_byte1};
   assign spd  = {in_frame.data_byte2, in_frame.data_byte3};
   assign trq  = {in_frame.data_byte4, in_frame.data_byte5};
   assign dspd = {spd[15], spd} - {last_spd_ff[15], last_spd_ff};

   // one-revolution unwrap of the 16-bit wrapped difference
   assign diff16 = pos - last_pos_ff;
   assign d_raw  = {{(STEP_W-16){diff16[15]}}, diff16};
   assign d_lo   = (d_raw < -ENC_HALF_S) ? d_raw + ENC_COUNTS_S : d_raw;
   assign d_fix  = (d_lo > ENC_HALF_S) ? d_lo - ENC_COUNTS_S : d_lo;
   // first frame seeds the absolute count and steps by zero
   assign step     = have_prev_ff ? d_fix : '0;
   assign abs_base = have_prev_ff ? abs_total_ff : {{16{pos[15]}}, pos};
   assign rel_next = sat_add(rel_total_ff, step);
   assign abs_next = sat_add(abs_base, step);

   always_comb begin
      have_prev_in = have_prev_ff;
      last_pos_in  = last_pos_ff;
      last_spd_in  = last_spd_ff;
      rel_total_in = rel_total_ff;
      abs_total_in = abs_total_ff;
      if (advance && hit) begin
         have_prev_in = 1'b1;
         last_pos_in  = pos;
         last_spd_in  = spd;
         rel_total_in = rel_next;
         abs_total_in = abs_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         last_pos_ff  <= '0;
         last_spd_ff  <= '0;
         rel_total_ff <= '0;
         abs_total_ff <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         last_pos_ff  <= last_pos_in;
         last_spd_ff  <= last_spd_in;
         rel_total_ff <= rel_total_in;
         abs_total_ff <= abs_total_in;
      end
   end

   always_comb begin
      result = '0;
      if (hit) begin
         result.matched          = 1'b1;
         result.raw_position     = pos;
         result.shaft_speed      = spd;
         result.torque_value     = trq;
         result.torque_is_output = (cfg.motor_kind == KIND_GEAR_OUTPUT);
         result.temperature      = in_frame.data_byte6;
         result.speed_change     = dspd;
         result.relative_count   = rel_next;
         result.absolute_count   = abs_next;
      end
   end

   `MFEU_ASSERT_NEXT(a_prev_sticky, clock, reset, have_prev_ff, have_prev_ff,
      "seen-frame flag dropped")
   `MFEU_ASSERT_NOW(a_step_range, clock, reset, advance && hit && have_prev_ff,
      (step == d_raw) || (step == d_raw + ENC_COUNTS_S) || (step == d_raw - ENC_COUNTS_S),
      "unwrapped step off by more than one revolution")
   `MFEU_ASSERT_NEXT(a_miss_no_update, clock, reset, !(advance && hit),
      $stable(rel_total_ff) && $stable(abs_total_ff) && $stable(last_pos_ff),
      "state changed without a matching frame")

endmodule

`default_nettype wire

FILE: src/motor_feedback_encoder_unwrap_core.sv
// Motor feedback decoder with multi-turn encoder unwrap. Each request beat is one
// received frame (identifier plus seven data bytes); each yields exactly one response
// beat via the input and response registers. A frame for another identifier returns
// matched = 0 with all other fields zero and leaves the running state alone. One frame
// per cycle is sustained while rsp_tready is held high: an input register feeds a
// single pass of decode, unwrap and saturating add into the response register.
// Registers: index 0 match_id (reset 513), index 1 motor_kind (reset 1); write them
// only while no frame is in flight. Depends on mfeu_pkg, mfeu_in_reg, mfeu_track.
`default_nettype none
`include "motor_feedback_encoder_unwrap_core_defines.svh"

module motor_feedback_encoder_unwrap_core
   import mfeu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic                   csr_addr,
   input  wire logic [10:0]            csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // frame_id[10:0], data_byte0[18:11] .. data_byte6[66:59], zero [71:67]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // raw_position[15:0], shaft_speed[31:16], torque_value[47:32],
   // temperature[55:48], speed_change[72:56], relative_count[104:73],
   // absolute_count[136:105], zero [143:137]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // matched[0], torque_is_output[1]
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   cfg_type    cfg_ff, cfg_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       advance;
   logic       in_valid;
   frame_type  in_frame;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MATCH_ID:   cfg_in.match_id   = csr_wdata;
            CSR_MOTOR_KIND: cfg_in.motor_kind = csr_wdata[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance = in_valid && (!out_valid_ff || rsp_tready);

   mfeu_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_frame   (in_frame)
   );

   mfeu_track u_track (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_frame (in_frame),
      .cfg      (cfg_ff),
      .result   (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_id   <= MATCH_ID_RST;
         cfg_ff.motor_kind <= KIND_CURRENT;
         out_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.torque_is_output, out_ff.matched};
   assign rsp_tdata  = {7'd0,
                        out_ff.absolute_count,
                        out_ff.relative_count,
                        out_ff.speed_change,
                        out_ff.temperature,
                        out_ff.torque_value,
                        out_ff.shaft_speed,
                        out_ff.raw_position};

   `MFEU_ASSERT_NOW(a_miss_zero, clock, reset, out_valid_ff && !out_ff.matched,
      (rsp_tdata == '0) && !out_ff.torque_is_output, "unmatched beat carries data")
   `MFEU_ASSERT_NEXT(a_handoff, clock, reset, advance, out_valid_ff,
      "frame lost between input and response register")
   `MFEU_ASSERT_NOW(a_stall_full, clock, reset, !req_tready,
      in_valid && out_valid_ff && !rsp_tready, "request stalled with room in the pipe")

endmodule

`default_nettype wire

FILE: tb/motor_feedback_encoder_unwrap_core_test.sv
// Self-checking testbench for the motor feedback decoder and multi-turn unwrap core.
// Streams frames through the block under random back-pressure and checks every response
// beat against a local tracker. Depends on mfeu_pkg and motor_feedback_encoder_unwrap_core.
`default_nettype none

module motor_feedback_encoder_unwrap_core_test;
   import mfeu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int HALF_REV    = ENC_COUNTS / 2;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483647 - 64'sd1;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic                   csr_addr   = CSR_MATCH_ID;
   logic [10:0]            csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   motor_feedback_encoder_unwrap_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // tracker copy of configuration and running state
   logic [10:0]        cfg_match_id = MATCH_ID_RST;
   logic [1:0]         cfg_kind     = KIND_CURRENT;
   logic               seen_frame   = 1'b0;
   logic signed [15:0] last_pos_q   = '0;
   logic signed [15:0] last_speed_q = '0;
   logic signed [31:0] rel_total    = '0;
   logic signed [31:0] abs_total    = '0;

   frame_type   frame_q[$];
   result_type  feedback_q[$];
   frame_type   cur_frame;
   logic [15:0] gen_pos = '0;

   int queued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int error_count    = 0;
   int stall_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   logic hold_trigger = 1'b0;
   logic req_taken    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int sat_add32(input int a, input int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > I32_MAX) return int'(I32_MAX);
      if (s < I32_MIN) return int'(I32_MIN);
      return int'(s);
   endfunction

   // Decode one accepted frame and, if it matches, advance the multi-turn tracking state.
   function automatic result_type track_frame(input frame_type f);
      result_type         r;
      logic signed [15:0] pos;
      logic signed [15:0] spd;
      logic signed [15:0] diff;
      int                 step;
      r = '0;
      if (f.frame_id != cfg_match_id) return r;
      pos = {f.data_byte0, f.data_byte1};
      spd = {f.data_byte2, f.data_byte3};
      r.matched          = 1'b1;
      r.raw_position     = pos;
      r.shaft_speed      = spd;
      r.torque_value     = {f.data_byte4, f.data_byte5};
      r.torque_is_output = (cfg_kind == KIND_GEAR_OUTPUT);
      r.temperature      = f.data_byte6;
      r.speed_change     = 17'(int'(spd) - int'(last_speed_q));
      last_speed_q = spd;
      if (!seen_frame) begin
         seen_frame = 1'b1;
         last_pos_q = pos;
         abs_total  = 32'(pos);
      end
      diff = pos - last_pos_q;
      step = int'(diff);
      if (step < -HALF_REV) step += ENC_COUNTS;
      if (step > HALF_REV) step -= ENC_COUNTS;
      rel_total  = sat_add32(rel_total, step);
      abs_total  = sat_add32(abs_total, step);
      last_pos_q = pos;
      r.relative_count = rel_total;
      r.absolute_count = abs_total;
      return r;
   endfunction

   function automatic frame_type make_frame(input logic [10:0] id, input logic [15:0] pos,
                                            input logic [15:0] spd, input logic [15:0] trq,
                                            input logic [7:0] temp);
      frame_type f;
      f.frame_id = id;
      {f.data_byte0, f.data_byte1} = pos;
      {f.data_byte2, f.data_byte3} = spd;
      {f.data_byte4, f.data_byte5} = trq;
      f.data_byte6 = temp;
      return f;
   endfunction

   task automatic queue_frame(input frame_type f);
      frame_q.push_back(f);
      queued_count++;
      if (f.frame_id == cfg_match_id) gen_pos = {f.data_byte0, f.data_byte1};
   endtask

   task automatic write_csr(input logic addr, input logic [10:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_MATCH_ID) cfg_match_id = value;
      else cfg_kind = value[1:0];
   endtask

   task automatic set_motor(input logic [10:0] id, input logic [1:0] kind, input int mode);
      write_csr(CSR_MATCH_ID, id);
      write_csr(CSR_MOTOR_KIND, {9'd0, kind});
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
         default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || checked_count != accepted_count)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly matching frames whose positions walk around the unwrap thresholds.
   task automatic queue_random(input int count);
      frame_type   f;
      logic [95:0] bits;
      logic [15:0] pos;
      int          roll;
      int          k;
      @(posedge clock);
      for (k = 0; k < count; k++) begin
         bits = {$urandom(), $urandom(), $urandom()};
         f    = bits[66:0];
         roll = $urandom_range(99);
         if (roll < 75) f.frame_id = cfg_match_id;
         else if (roll < 85) f.frame_id = cfg_match_id + ($urandom_range(1) ? 11'd1 : -11'd1);
         if (f.frame_id == cfg_match_id) begin
            pos = {f.data_byte0, f.data_byte1};
            case ($urandom_range(5))
               0: pos = gen_pos + 16'($urandom_range(128)) - 16'd64;
               1: pos = gen_pos + 16'd4094 + 16'($urandom_range(4));
               2: pos = gen_pos - 16'd4094 - 16'($urandom_range(4));
               3: pos = gen_pos + ($urandom_range(1) ? 16'd8190 : -16'd8194)
                        + 16'($urandom_range(4));
               4: begin
                  case ($urandom_range(3))
                     0: pos = 16'h7fff;
                     1: pos = 16'h8000;
                     2: pos = 16'h0000;
                     default: pos = 16'hffff;
                  endcase
               end
               default: ;
            endcase
            {f.data_byte0, f.data_byte1} = pos;
            if ($urandom_range(7) == 0)
               {f.data_byte2, f.data_byte3} = $urandom_range(1) ? 16'h7fff : 16'h8000;
         end
         queue_frame(f);
      end
   endtask

   // Full-scale position steps every frame: the largest unwrapped steps downward,
   // then the largest ones upward.
   task automatic queue_saturation();
      int k;
      for (k = 0; k < 40; k++) begin
         if (k % 32 == 0) begin
            while (queued_count - accepted_count > 64) @(negedge clock);
            @(posedge clock);
         end
         if (k < 20)
            queue_frame(make_frame(cfg_match_id, k[0] ? 16'h8000 : 16'h0000,
                                   16'($urandom()), 16'($urandom()), 8'($urandom())));
         else
            queue_frame(make_frame(cfg_match_id, gen_pos + 16'h7fff,
                                   16'($urandom()), 16'($urandom()), 8'($urandom())));
      end
   endtask

   // Frame driver
   always @(negedge clock) begin
      frame_type nf;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nf = frame_q.pop_front();
            cur_frame  <= nf;
            req_tdata  <= {5'd0, nf.data_byte6, nf.data_byte5, nf.data_byte4, nf.data_byte3,
                           nf.data_byte2, nf.data_byte1, nf.data_byte0, nf.frame_id};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure, with a long hold-off when the stimulus triggers one
   always @(negedge clock) begin
      if (hold_trigger && hold_left == 0) begin
         hold_left    = HOLD_CYCLES;
         hold_trigger = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input longint want_v, input longint got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   // Monitor: track accepted frames, compare response beats in order
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            feedback_q.push_back(track_frame(cur_frame));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.matched          = rsp_tuser[0];
            got.torque_is_output = rsp_tuser[1];
            got.raw_position     = rsp_tdata[15:0];
            got.shaft_speed      = rsp_tdata[31:16];
            got.torque_value     = rsp_tdata[47:32];
            got.temperature      = rsp_tdata[55:48];
            got.speed_change     = rsp_tdata[72:56];
            got.relative_count   = rsp_tdata[104:73];
            got.absolute_count   = rsp_tdata[136:105];
            checked_count++;
            if (feedback_q.size() == 0) begin
               $error("response beat with no frame pending");
               error_count++;
            end else begin
               want = feedback_q.pop_front();
               check_field("matched", want.matched, got.matched);
               check_field("raw_position", want.raw_position, got.raw_position);
               check_field("shaft_speed", want.shaft_speed, got.shaft_speed);
               check_field("torque_value", want.torque_value, got.torque_value);
               check_field("torque_is_output", want.torque_is_output, got.torque_is_output);
               check_field("temperature", want.temperature, got.temperature);
               check_field("speed_change", want.speed_change, got.speed_change);
               check_field("relative_count", want.relative_count, got.relative_count);
               check_field("absolute_count", want.absolute_count, got.absolute_count);
            end
         end
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames at reset configuration
      @(posedge clock);
      queue_frame(make_frame(11'd0,    16'hffff, 16'hffff, 16'hffff, 8'hff));
      queue_frame(make_frame(11'd2047, 16'h1234, 16'h5678, 16'h9abc, 8'h5a));
      queue_frame(make_frame(11'd512,  16'h0100, 16'h0200, 16'h0300, 8'h04));
      queue_frame(make_frame(11'd514,  16'h0100, 16'h0200, 16'h0300, 8'h04));
      queue_frame(make_frame(11'd513,  16'h1000, 16'h7fff, 16'h8000, 8'hff)); // seeds count
      queue_frame(make_frame(11'd513,  16'h2000, 16'h8000, 16'h7fff, 8'h00)); // step +half
      queue_frame(make_frame(11'd513,  16'h3001, 16'h7fff, 16'h0000, 8'h80)); // wraps down
      queue_frame(make_frame(11'd513,  16'h2001, 16'h0000, 16'hffff, 8'h01)); // step -half
      queue_frame(make_frame(11'd513,  16'h1000, 16'h0001, 16'h0001, 8'h7f)); // wraps up
      queue_frame(make_frame(11'd513,  16'h8000, 16'hffff, 16'h8000, 8'hfe));
      queue_frame(make_frame(11'd513,  16'h7fff, 16'h8000, 16'h7fff, 8'h10));
      queue_frame(make_frame(11'd513,  16'h8000, 16'h7fff, 16'h0000, 8'h20));
      queue_frame(make_frame(11'd513,  16'h0000, 16'h0000, 16'h8000, 8'h40));
      queue_frame(make_frame(11'd513,  16'h7fff, 16'h1234, 16'h4321, 8'h55));
      queue_frame(make_frame(11'd513,  16'hffff, 16'hffff, 16'hffff, 8'hff));
      queue_frame(make_frame(11'd1,    16'h0000, 16'h0000, 16'h0000, 8'h00));
      wait_drained();

      set_motor(11'd513, KIND_CURRENT, 1);
      queue_random(200);
      wait_drained();

      set_motor(11'd0, KIND_GEAR_OUTPUT, 2);
      queue_random(200);
      wait_drained();

      set_motor(11'd2047, KIND_VOLTAGE, 3);
      queue_random(200);
      wait_drained();

      // response side held off while frames keep coming, then a full drain
      set_motor(11'($urandom()), 2'd3, 0);
      @(posedge clock);
      hold_trigger = 1'b1;
      queue_random(60);
      wait_drained();
      queue_random(150);
      wait_drained();

      set_motor(11'($urandom()), 2'($urandom_range(2)), 3);
      queue_random(200);
      wait_drained();

      set_motor(11'($urandom()), KIND_GEAR_OUTPUT, 0);
      queue_saturation();
      wait_drained();

      set_motor(11'd2047, KIND_CURRENT, 3);
      queue_random(20);
      wait_drained();

      repeat (20) @(posedge clock);
      if (feedback_q.size() != 0) begin
         $error("%0d expected responses never arrived", feedback_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
